// ===== hdl/pcsp_pkg.sv =====
package pcsp_pkg;

	// Parser phases of the front end.
	typedef enum logic [2:0] {
		PH_SIG,
		PH_LEN,
		PH_TYPE,
		PH_DATA,
		PH_CRC,
		PH_HALT
	} phase_t;

	// Classified byte operations handed from the front end to the back end.
	typedef enum logic [2:0] {
		OP_BAD_SIG,
		OP_EXTENT,
		OP_TYPE,
		OP_DATA,
		OP_CRC
	} op_t;

	// Result kinds on the output stream.
	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_RECORD = 2'd1,
		KIND_BADSIG = 2'd2,
		KIND_EXTENT = 2'd3
	} kind_t;

	localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
	localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;
	localparam logic [33:0] CHUNK_OVERHEAD = 34'd12;
	localparam logic [2:0]  SIG_LAST = 3'd7;
	localparam logic [1:0]  FIELD_LAST = 2'd3;
	localparam int unsigned TDATA_OUT_W = 144;

	// One token in the queue between front and back.
	typedef struct packed {
		op_t         op;
		logic [7:0]  byte_val;
		logic        first;   // first type byte: restart the CRC
		logic        last;    // last stored CRC byte: emit the record
		logic [31:0] length;
		logic [31:0] offset;
	} token_t;

	// One result item.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [31:0] chunk_length;
		logic [31:0] chunk_type;
		logic [31:0] chunk_offset;
		logic [31:0] stored_crc;
		logic        crc_ok;
		logic        critical;
		logic        public_flag;
		logic        reserved_flag;
		logic        copy_safe;
	} result_t;

	// Expected byte of the eight-byte file signature.
	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] v;
		unique case (idx)
			3'd0: v = 8'h89;
			3'd1: v = 8'h50;
			3'd2: v = 8'h4e;
			3'd3: v = 8'h47;
			3'd4: v = 8'h0d;
			3'd5: v = 8'h0a;
			3'd6: v = 8'h1a;
			default: v = 8'h0a;
		endcase
		return v;
	endfunction

	// Reflected CRC-32, one byte per call.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hdl/png_chunk_stream_parser_top.sv =====
// Channel   Direction  Handshake             Payload
// s_        in         s_tvalid / s_tready   tdata: byte_value; tuser: file_start
// m_        out        m_tvalid / m_tready   tdata: record fields; tuser: kind
// cfg_      in         cfg_we (no stall)     cfg_wdata: file_size
//
// One input item is taken per clock while the token queue has room; the front
// parser classifies every byte in the cycle it arrives, so the rate is one item
// per cycle, set by the single byte-wide CRC-32 update in the back end.
// A result is loaded into the output register at the edge that pops its token,
// after that token has been written into the token queue.
// Output stalls fill the queue (FIFO_DEPTH tokens); only then does s_tready fall.
// Reset is asynchronous and active low; it clears parser state, queue pointers and output valid.
module png_chunk_stream_parser_top #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] byte_value
	input  logic         s_tuser,   // [0] file_start
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] data_byte, [39:8] chunk_length, [71:40] chunk_type,
	// [103:72] chunk_offset, [135:104] stored_crc, [136] crc_ok,
	// [137] critical, [138] public_flag, [139] reserved_flag,
	// [140] copy_safe, [143:141] zero
	output logic [pcsp_pkg::TDATA_OUT_W-1:0] m_tdata,
	output logic [1:0]   m_tuser,   // [1:0] kind
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata
);

	// The file size register bounds every chunk's extent. The user must write it only while
	// the block is idle (the block does not enforce this), so the front parser may read it directly.
	logic [31:0] file_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= '0;
		end else if (cfg_we) begin
			file_size_q <= cfg_wdata;
		end
	end

	logic              accept;
	logic              push;
	logic              pop;
	logic              full;
	logic              empty;
	pcsp_pkg::token_t  wr_token;
	pcsp_pkg::token_t  rd_token;
	pcsp_pkg::result_t result;

	// The front side only waits on queue space, never on the output.
	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	pcsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.byte_value (s_tdata),
		.file_start (s_tuser),
		.file_size  (file_size_q),
		.push       (push),
		.token      (wr_token)
	);

	// Pushes are qualified by the accept so idle cycles leave no token.
	pcsp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push && accept),
		.wr_data (wr_token),
		.pop     (pop),
		.rd_data (rd_token),
		.full    (full),
		.empty   (empty)
	);

	pcsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.token     (rd_token),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result)
	);

	// Pack the result item onto the stream bus, lowest field first.
	assign m_tuser = result.kind;
	assign m_tdata = {3'b000,
		result.copy_safe, result.reserved_flag, result.public_flag,
		result.critical, result.crc_ok,
		result.stored_crc, result.chunk_offset, result.chunk_type,
		result.chunk_length, result.data_byte};

endmodule

// ===== hdl/pcsp_front.sv =====
module pcsp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           byte_value,
	input  logic                 file_start,
	input  logic [31:0]          file_size,
	output logic                 push,
	output pcsp_pkg::token_t     token
);

	pcsp_pkg::phase_t phase_q, phase_d;
	logic [2:0]  fcount_q, fcount_d;
	logic [31:0] position_q, position_d;
	logic [31:0] length_q, length_d;
	logic [31:0] remaining_q, remaining_d;
	logic [31:0] offset_q, offset_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= pcsp_pkg::PH_SIG;
			fcount_q    <= '0;
			position_q  <= '0;
			length_q    <= '0;
			remaining_q <= '0;
			offset_q    <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			fcount_q    <= fcount_d;
			position_q  <= position_d;
			length_q    <= length_d;
			remaining_q <= remaining_d;
			offset_q    <= offset_d;
		end
	end

	always_comb begin
		pcsp_pkg::phase_t ph;
		logic [2:0]  fc;
		logic [31:0] pos;
		logic [31:0] len_n;
		logic [33:0] extent;

		// A file start byte restarts parsing before it is classified.
		ph          = file_start ? pcsp_pkg::PH_SIG : phase_q;
		fc          = file_start ? 3'd0 : fcount_q;
		pos         = file_start ? 32'd0 : position_q;
		phase_d     = ph;
		fcount_d    = fc;
		position_d  = pos + 32'd1;
		length_d    = file_start ? 32'd0 : length_q;
		remaining_d = file_start ? 32'd0 : remaining_q;
		offset_d    = file_start ? 32'd0 : offset_q;
		len_n       = {length_d[23:0], byte_value};
		extent      = {2'b00, offset_d} + {2'b00, len_n} + pcsp_pkg::CHUNK_OVERHEAD;

		push           = 1'b0;
		token.op       = pcsp_pkg::OP_DATA;
		token.byte_val = byte_value;
		token.first    = 1'b0;
		token.last     = 1'b0;
		token.length   = length_d;
		token.offset   = offset_d;

		unique case (ph)
			pcsp_pkg::PH_SIG: begin
				if (byte_value != pcsp_pkg::sig_byte(fc)) begin
					push     = 1'b1;
					token.op = pcsp_pkg::OP_BAD_SIG;
					phase_d  = pcsp_pkg::PH_HALT;
				end else if (fc == pcsp_pkg::SIG_LAST) begin
					fcount_d = '0;
					phase_d  = pcsp_pkg::PH_LEN;
					offset_d = pos + 32'd1;
					length_d = '0;
				end else begin
					fcount_d = fc + 3'd1;
				end
			end
			pcsp_pkg::PH_LEN: begin
				length_d = len_n;
				if (fc[1:0] == pcsp_pkg::FIELD_LAST) begin
					fcount_d = '0;
					if (extent > {2'b00, file_size}) begin
						push         = 1'b1;
						token.op     = pcsp_pkg::OP_EXTENT;
						token.length = len_n;
						phase_d      = pcsp_pkg::PH_HALT;
					end else begin
						phase_d = pcsp_pkg::PH_TYPE;
					end
				end else begin
					fcount_d = fc + 3'd1;
				end
			end
			pcsp_pkg::PH_TYPE: begin
				push        = 1'b1;
				token.op    = pcsp_pkg::OP_TYPE;
				token.first = (fc == 3'd0);
				if (fc[1:0] == pcsp_pkg::FIELD_LAST) begin
					fcount_d = '0;
					if (length_d == 32'd0) begin
						phase_d = pcsp_pkg::PH_CRC;
					end else begin
						remaining_d = length_d;
						phase_d     = pcsp_pkg::PH_DATA;
					end
				end else begin
					fcount_d = fc + 3'd1;
				end
			end
			pcsp_pkg::PH_DATA: begin
				push        = 1'b1;
				token.op    = pcsp_pkg::OP_DATA;
				remaining_d = remaining_d - 32'd1;
				if (remaining_d == 32'd0) begin
					phase_d = pcsp_pkg::PH_CRC;
				end
			end
			pcsp_pkg::PH_CRC: begin
				push     = 1'b1;
				token.op = pcsp_pkg::OP_CRC;
				if (fc[1:0] == pcsp_pkg::FIELD_LAST) begin
					token.last = 1'b1;
					fcount_d   = '0;
					phase_d    = pcsp_pkg::PH_LEN;
					offset_d   = pos + 32'd1;
					length_d   = '0;
				end else begin
					fcount_d = fc + 3'd1;
				end
			end
			pcsp_pkg::PH_HALT: begin
				// Bytes are dropped until the next file start.
				position_d = position_q;
			end
			default: begin
				phase_d = pcsp_pkg::PH_HALT;
			end
		endcase
	end

endmodule

// ===== hdl/pcsp_fifo.sv =====
module pcsp_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pcsp_pkg::token_t wr_data,
	input  logic             pop,
	output pcsp_pkg::token_t rd_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	pcsp_pkg::token_t mem [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("token queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("token queue read while empty");
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("token queue count lost a write");
`endif

endmodule

// ===== hdl/pcsp_back.sv =====
module pcsp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  pcsp_pkg::token_t  token,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output pcsp_pkg::result_t result
);

	logic              out_valid_q;
	pcsp_pkg::result_t result_q;
	logic [31:0]       type_q;
	logic [31:0]       crc_q;
	logic [31:0]       crc_read_q;

	logic              emit;
	pcsp_pkg::result_t res_d;
	logic [31:0]       type_d, crc_d, crc_read_d;

	assign pop       = !empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	always_comb begin
		logic [31:0] crc_base;
		crc_base   = token.first ? pcsp_pkg::CRC_PRESET : crc_q;
		type_d     = type_q;
		crc_d      = crc_q;
		crc_read_d = crc_read_q;
		emit       = 1'b0;
		res_d      = '0;
		unique case (token.op)
			pcsp_pkg::OP_BAD_SIG: begin
				emit       = 1'b1;
				res_d.kind = pcsp_pkg::KIND_BADSIG;
			end
			pcsp_pkg::OP_EXTENT: begin
				emit               = 1'b1;
				res_d.kind         = pcsp_pkg::KIND_EXTENT;
				res_d.chunk_length = token.length;
				res_d.chunk_offset = token.offset;
			end
			pcsp_pkg::OP_TYPE: begin
				type_d = {type_q[23:0], token.byte_val};
				crc_d  = pcsp_pkg::crc_byte(crc_base, token.byte_val);
			end
			pcsp_pkg::OP_DATA: begin
				emit            = 1'b1;
				res_d.kind      = pcsp_pkg::KIND_DATA;
				res_d.data_byte = token.byte_val;
				crc_d           = pcsp_pkg::crc_byte(crc_q, token.byte_val);
			end
			pcsp_pkg::OP_CRC: begin
				crc_read_d = {crc_read_q[23:0], token.byte_val};
				if (token.last) begin
					emit                = 1'b1;
					res_d.kind          = pcsp_pkg::KIND_RECORD;
					res_d.chunk_length  = token.length;
					res_d.chunk_type    = type_q;
					res_d.chunk_offset  = token.offset;
					res_d.stored_crc    = crc_read_d;
					res_d.crc_ok        = (~crc_q == crc_read_d);
					res_d.critical      = !type_q[29];
					res_d.public_flag   = !type_q[21];
					res_d.reserved_flag = !type_q[13];
					res_d.copy_safe     = type_q[5];
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			type_q     <= type_d;
			crc_q      <= crc_d;
			crc_read_q <= crc_read_d;
			if (emit) begin
				result_q <= res_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== tb/tb.sv =====
module tb;

	localparam int unsigned RANDOM_ITEMS  = 1000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam logic [63:0] PNG_MAGIC     = 64'h8950_4E47_0D0A_1A0A;

	typedef enum logic {
		ROW_BYTE,
		ROW_FILE_SIZE
	} row_op_t;

	// One line of the directed table. When hand_checked is set, expect_res holds the
	// result typed in by hand and replaces the predicted one.
	typedef struct {
		row_op_t           op;
		logic [31:0]       value;
		logic              start;
		bit                hand_checked;
		pcsp_pkg::result_t expect_res;
	} dir_row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [7:0]                       s_tdata;
	logic                             s_tuser;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [pcsp_pkg::TDATA_OUT_W-1:0] m_tdata;
	logic [1:0]                       m_tuser;
	logic                             cfg_we;
	logic [31:0]                      cfg_wdata;

	// Parser state mirrored by the predictor.
	pcsp_pkg::phase_t parse_phase  = pcsp_pkg::PH_SIG;
	logic [2:0]       field_idx    = '0;
	logic [31:0]      byte_pos     = '0;
	logic [31:0]      declared_len = '0;
	logic [31:0]      data_left    = '0;
	logic [31:0]      type_acc     = '0;
	logic [31:0]      trailer_crc  = '0;
	logic [31:0]      crc_acc      = pcsp_pkg::CRC_PRESET;
	logic [31:0]      chunk_start  = '0;
	logic [31:0]      file_size_cfg = '0;
	bit               byte_ignored;

	pcsp_pkg::result_t pending_results[$];
	int                error_count   = 0;
	int unsigned       items_parsed  = 0;
	int                send_quiet    = 0;
	int                recv_quiet    = 0;

	png_chunk_stream_parser_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ pcsp_pkg::CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Advances the mirrored parser by one byte; returns 1 when the byte yields a result.
	function automatic bit parse_png_byte(input logic [7:0] b, input logic st,
			output pcsp_pkg::result_t r);
		logic [33:0] extent;
		bit got;
		got = 1'b0;
		r = '0;
		if (st) begin
			parse_phase  = pcsp_pkg::PH_SIG;
			field_idx    = '0;
			byte_pos     = '0;
			declared_len = '0;
			data_left    = '0;
			type_acc     = '0;
			trailer_crc  = '0;
			crc_acc      = pcsp_pkg::CRC_PRESET;
			chunk_start  = '0;
		end
		byte_ignored = (parse_phase == pcsp_pkg::PH_HALT);
		if (byte_ignored) begin
			return 1'b0;
		end
		case (parse_phase)
			pcsp_pkg::PH_SIG: begin
				if (b != PNG_MAGIC[63 - 8*field_idx -: 8]) begin
					r.kind = pcsp_pkg::KIND_BADSIG;
					got = 1'b1;
					parse_phase = pcsp_pkg::PH_HALT;
				end else if (field_idx == pcsp_pkg::SIG_LAST) begin
					field_idx = '0;
					parse_phase = pcsp_pkg::PH_LEN;
					chunk_start = byte_pos + 1;
					declared_len = '0;
				end else begin
					field_idx++;
				end
			end
			pcsp_pkg::PH_LEN: begin
				declared_len = {declared_len[23:0], b};
				if (field_idx == pcsp_pkg::FIELD_LAST) begin
					field_idx = '0;
					// The extent is summed in 34 bits so that it cannot wrap.
					extent = {2'b0, chunk_start} + {2'b0, declared_len}
						+ pcsp_pkg::CHUNK_OVERHEAD;
					if (extent > {2'b0, file_size_cfg}) begin
						r.kind = pcsp_pkg::KIND_EXTENT;
						r.chunk_length = declared_len;
						r.chunk_offset = chunk_start;
						got = 1'b1;
						parse_phase = pcsp_pkg::PH_HALT;
					end else begin
						parse_phase = pcsp_pkg::PH_TYPE;
						type_acc = '0;
						crc_acc = pcsp_pkg::CRC_PRESET;
					end
				end else begin
					field_idx++;
				end
			end
			pcsp_pkg::PH_TYPE: begin
				type_acc = {type_acc[23:0], b};
				crc_acc = crc32_next(crc_acc, b);
				if (field_idx == pcsp_pkg::FIELD_LAST) begin
					field_idx = '0;
					trailer_crc = '0;
					if (declared_len == 0) begin
						parse_phase = pcsp_pkg::PH_CRC;
					end else begin
						data_left = declared_len;
						parse_phase = pcsp_pkg::PH_DATA;
					end
				end else begin
					field_idx++;
				end
			end
			pcsp_pkg::PH_DATA: begin
				crc_acc = crc32_next(crc_acc, b);
				r.kind = pcsp_pkg::KIND_DATA;
				r.data_byte = b;
				got = 1'b1;
				data_left--;
				if (data_left == 0) begin
					parse_phase = pcsp_pkg::PH_CRC;
				end
			end
			default: begin
				trailer_crc = {trailer_crc[23:0], b};
				if (field_idx == pcsp_pkg::FIELD_LAST) begin
					field_idx = '0;
					r.kind = pcsp_pkg::KIND_RECORD;
					r.chunk_length = declared_len;
					r.chunk_type = type_acc;
					r.chunk_offset = chunk_start;
					r.stored_crc = trailer_crc;
					r.crc_ok = ((crc_acc ^ pcsp_pkg::CRC_PRESET) == trailer_crc);
					// Case bits of the four type letters.
					r.critical = !type_acc[29];
					r.public_flag = !type_acc[21];
					r.reserved_flag = !type_acc[13];
					r.copy_safe = type_acc[5];
					got = 1'b1;
					parse_phase = pcsp_pkg::PH_LEN;
					chunk_start = byte_pos + 1;
					declared_len = '0;
					crc_acc = pcsp_pkg::CRC_PRESET;
				end else begin
					field_idx++;
				end
			end
		endcase
		byte_pos++;
		return got;
	endfunction

	// Mostly a uniform random wait, with occasional runs of back-to-back items.
	function automatic int draw_wait(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			quiet_left = $urandom_range(16, 64);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	function automatic string result_text(input pcsp_pkg::result_t r);
		return $sformatf("kind=%0d byte=%h len=%h type=%h off=%h crc=%h ok=%b flags=%b%b%b%b",
			r.kind, r.data_byte, r.chunk_length, r.chunk_type, r.chunk_offset, r.stored_crc,
			r.crc_ok, r.critical, r.public_flag, r.reserved_flag, r.copy_safe);
	endfunction

	function automatic dir_row_t byte_row(input logic [7:0] v, input logic st);
		dir_row_t row;
		row.op = ROW_BYTE;
		row.value = {24'd0, v};
		row.start = st;
		row.hand_checked = 1'b0;
		row.expect_res = '0;
		return row;
	endfunction

	// flags: {copy_safe, reserved_flag, public_flag, critical, crc_ok}
	function automatic dir_row_t typed_row(input logic [7:0] v, input logic st,
			input pcsp_pkg::kind_t k,
			input logic [31:0] len, input logic [31:0] ctype, input logic [31:0] off,
			input logic [31:0] crc, input logic [4:0] flags);
		dir_row_t row;
		row = byte_row(v, st);
		row.hand_checked = 1'b1;
		row.expect_res.kind = k;
		row.expect_res.chunk_length = len;
		row.expect_res.chunk_type = ctype;
		row.expect_res.chunk_offset = off;
		row.expect_res.stored_crc = crc;
		{row.expect_res.copy_safe, row.expect_res.reserved_flag, row.expect_res.public_flag,
			row.expect_res.critical, row.expect_res.crc_ok} = flags;
		return row;
	endfunction

	function automatic dir_row_t size_row(input logic [31:0] v);
		dir_row_t row;
		row = byte_row(8'h00, 1'b0);
		row.op = ROW_FILE_SIZE;
		row.value = v;
		return row;
	endfunction

	task automatic send_item(input logic [7:0] b, input logic st, input bit hand_checked = 1'b0,
			input pcsp_pkg::result_t hand_res = '0);
		int gap;
		pcsp_pkg::result_t r;
		bit got;
		gap = draw_wait(send_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		do @(posedge clk); while (!s_tready);
		got = parse_png_byte(b, st, r);
		if (!byte_ignored) begin
			items_parsed++;
		end
		if (hand_checked) begin
			pending_results = {pending_results, hand_res};
		end else if (got) begin
			pending_results = {pending_results, r};
		end
	endtask

	// Holds the sender until every expected result is out and the pipe has emptied.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_file_size(input logic [31:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		file_size_cfg = v;
	endtask

	always @(posedge clk) begin
		pcsp_pkg::result_t seen;
		pcsp_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = '0;
			seen.kind = pcsp_pkg::kind_t'(m_tuser);
			seen.data_byte = m_tdata[7:0];
			seen.chunk_length = m_tdata[39:8];
			seen.chunk_type = m_tdata[71:40];
			seen.chunk_offset = m_tdata[103:72];
			seen.stored_crc = m_tdata[135:104];
			seen.crc_ok = m_tdata[136];
			seen.critical = m_tdata[137];
			seen.public_flag = m_tdata[138];
			seen.reserved_flag = m_tdata[139];
			seen.copy_safe = m_tdata[140];
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS) begin
					$display("ERROR: result with nothing expected: %s", result_text(seen));
				end
			end else begin
				want = pending_results.pop_front();
				if (seen.kind !== want.kind || seen.data_byte !== want.data_byte ||
						seen.chunk_length !== want.chunk_length ||
						seen.chunk_type !== want.chunk_type ||
						seen.chunk_offset !== want.chunk_offset ||
						seen.stored_crc !== want.stored_crc || seen.crc_ok !== want.crc_ok ||
						seen.critical !== want.critical ||
						seen.public_flag !== want.public_flag ||
						seen.reserved_flag !== want.reserved_flag ||
						seen.copy_safe !== want.copy_safe) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("ERROR: result mismatch\n  expected %s\n  actual   %s",
							result_text(want), result_text(seen));
					end
				end
			end
		end
	end

	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(recv_quiet);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin : stimulus
		dir_row_t          rows[$];
		int unsigned       lens[4];
		int                n_chunks;
		int                sel;
		int                bad_sig_at;
		longint unsigned   total;
		logic [31:0]       fsize;
		logic [31:0]       field;
		logic [31:0]       crc;
		logic [7:0]        b;
		bit                broken;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;

		rows = '{
			// Straight out of reset, with no file started: a wrong first byte.
			typed_row(8'h00, 1'b0, pcsp_pkg::KIND_BADSIG,
				32'h0, 32'h0, 32'h0, 32'h0, 5'b00000),
			byte_row(8'hFF, 1'b0),            // halted, so ignored
			size_row(32'd20),                 // exactly one empty chunk fits
			byte_row(8'h89, 1'b1),
			byte_row(8'h50, 1'b0),
			byte_row(8'h4E, 1'b0),
			byte_row(8'h47, 1'b0),
			byte_row(8'h0D, 1'b0),
			byte_row(8'h0A, 1'b0),
			byte_row(8'h1A, 1'b0),
			byte_row(8'h0A, 1'b0),
			// Empty IEND chunk ending right at the file size.
			byte_row(8'h00, 1'b0),
			byte_row(8'h00, 1'b0),
			byte_row(8'h00, 1'b0),
			byte_row(8'h00, 1'b0),
			byte_row(8'h49, 1'b0),
			byte_row(8'h45, 1'b0),
			byte_row(8'h4E, 1'b0),
			byte_row(8'h44, 1'b0),
			byte_row(8'hAE, 1'b0),
			byte_row(8'h42, 1'b0),
			byte_row(8'h60, 1'b0),
			typed_row(8'h82, 1'b0, pcsp_pkg::KIND_RECORD, 32'h0, 32'h4945_4E44, 32'd8,
				32'hAE42_6082, 5'b01111),
			// A further chunk header past the end of the file.
			byte_row(8'h00, 1'b0),
			byte_row(8'h00, 1'b0),
			byte_row(8'h00, 1'b0),
			typed_row(8'h00, 1'b0, pcsp_pkg::KIND_EXTENT,
				32'h0, 32'h0, 32'd20, 32'h0, 5'b00000)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			if (rows[i].op == ROW_FILE_SIZE) begin
				set_file_size(rows[i].value);
			end else begin
				send_item(rows[i].value[7:0], rows[i].start, rows[i].hand_checked,
					rows[i].expect_res);
			end
		end

		items_parsed = 0;
		while (items_parsed < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				// Line noise: arbitrary bytes, now and then flagged as a file start.
				repeat ($urandom_range(8, 32)) begin
					send_item(8'($urandom()), $urandom_range(0, 5) == 0);
				end
			end else begin
				n_chunks = $urandom_range(1, 4);
				total = 8;
				for (int c = 0; c < n_chunks; c++) begin
					lens[c] = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 160)
						: $urandom_range(0, 16);
					total += 12 + lens[c];
				end
				// Half the files get their exact size; some are cut short so the last
				// chunk overruns, some get the extreme sizes and the rest a random size.
				sel = $urandom_range(0, 99);
				if (sel < 50) begin
					fsize = 32'(total);
				end else if (sel < 65) begin
					fsize = 32'(total) - $urandom_range(1, 12 + lens[n_chunks - 1]);
				end else if (sel < 75) begin
					fsize = 32'hFFFF_FFFF;
				end else if (sel < 82) begin
					fsize = '0;
				end else begin
					fsize = $urandom();
				end
				set_file_size(fsize);

				bad_sig_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : -1;
				for (int i = 0; i < 8; i++) begin
					b = PNG_MAGIC[63 - 8*i -: 8];
					if (i == bad_sig_at) begin
						b ^= 8'($urandom_range(1, 255));
					end
					send_item(b, i == 0 && $urandom_range(0, 19) != 0);
				end

				broken = 1'b0;
				for (int c = 0; c < n_chunks && !broken; c++) begin
					if ($urandom_range(0, 19) == 0) begin
						// Damaged length field followed by a few stray bytes; the
						// file is abandoned here.
						field = $urandom();
						for (int k = 3; k >= 0; k--) send_item(field[8*k +: 8], 1'b0);
						repeat ($urandom_range(0, 8)) send_item(8'($urandom()), 1'b0);
						broken = 1'b1;
					end else begin
						field = lens[c];
						for (int k = 3; k >= 0; k--) send_item(field[8*k +: 8], 1'b0);
						crc = pcsp_pkg::CRC_PRESET;
						for (int k = 0; k < 4; k++) begin
							if ($urandom_range(0, 7) == 0) begin
								b = 8'($urandom());
							end else begin
								b = 8'(8'h41 + $urandom_range(0, 25)) |
									8'($urandom_range(0, 1) << 5);
							end
							crc = crc32_next(crc, b);
							send_item(b, 1'b0);
						end
						for (int d = 0; d < lens[c]; d++) begin
							b = 8'($urandom());
							crc = crc32_next(crc, b);
							send_item(b, 1'b0);
						end
						field = ~crc;
						if ($urandom_range(0, 6) == 0) begin
							field ^= 32'd1 << $urandom_range(0, 31);
						end
						for (int k = 3; k >= 0; k--) send_item(field[8*k +: 8], 1'b0);
					end
				end
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 6)) send_item(8'($urandom()), 1'b0);
				end
			end
		end

		drain();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("ERROR: timeout with %0d results outstanding", pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/pcsp_pkg.sv
hdl/pcsp_front.sv
hdl/pcsp_fifo.sv
hdl/pcsp_back.sv
hdl/png_chunk_stream_parser_top.sv
tb/tb.sv
